// ----- hw/rtl/sedt_pkg.sv -----
`timescale 1ns / 1ps
package sedt_pkg;

  localparam int unsigned UNITS      = 65536;
  localparam int unsigned BLOCK_SIZE = 4096;
  localparam int unsigned MAP_WORDS  = (UNITS + 63) / 64;
  localparam int unsigned WORD_AW    = $clog2(MAP_WORDS);
  localparam int unsigned UNIT_W     = $clog2(UNITS);
  localparam int unsigned UB_SHIFT   = $clog2(BLOCK_SIZE);
  localparam int unsigned CAP_W      = 17;

  typedef enum logic [1:0] {
    KIND_RECORD  = 2'd0,
    KIND_OVERLAP = 2'd1,
    KIND_SUMMARY = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic {
    REG_SESSION_FILTER = 1'b0,
    REG_CAPACITY_UNITS = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        record_blank;
    logic [63:0] sess_no;
    logic [63:0] timestamp;
    logic [63:0] dev_off;
    logic [31:0] rec_len;
    logic [63:0] start_unit;
    logic [63:0] unit_count;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        overlaps;
    logic        any_record;
    logic [63:0] first_time;
    logic [63:0] last_time;
    logic [63:0] first_byte;
    logic [63:0] last_byte;
  } out_word_t;

  // Bits lo..hi of a map word.
  function automatic logic [63:0] bit_span(input logic [5:0] lo, input logic [5:0] hi);
    logic [63:0] m;
    m = ({64{1'b1}} >> (6'd63 - hi)) & ({64{1'b1}} << lo);
    return m;
  endfunction

  function automatic logic [5:0] lowest_bit(input logic [63:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (w[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] highest_bit(input logic [63:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sedt_map_ram.sv -----
`timescale 1ns / 1ps
module sedt_map_ram (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [sedt_pkg::WORD_AW-1:0]     wr_addr,
  input  logic [63:0]                      wr_data,
  input  logic [sedt_pkg::WORD_AW-1:0]     rd_addr,
  output logic [63:0]                      rd_data
);

  logic [63:0] mem [sedt_pkg::MAP_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/session_extent_tracker_unit.sv -----
`timescale 1ns / 1ps
// Session extent tracker. Each input word is a decoded log record or a query
// and yields exactly one output word. Matching records widen the earliest and
// latest timestamps and set the bits of every storage unit their byte range
// touches in a 1024 x 64 bit map memory; overlap queries test a unit range and
// summary queries scan the map for the lowest and highest marked unit. After
// reset the block clears every map word before in_ready rises; configuration
// writes are taken at any time. Each item is decoded and handed off, and
// every map word it visits is read through the single registered-read memory
// port and then checked or written back: a record visits the words its byte
// range touches, an overlap query each word in its range, and a summary query
// each word below capacity. Skipped records, out-of-range ranges and unused
// kinds visit no map word.
module session_extent_tracker_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sedt_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sedt_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned AW = sedt_pkg::WORD_AW;
  localparam int unsigned UW = sedt_pkg::UNIT_W;
  localparam int unsigned CW = sedt_pkg::CAP_W;
  localparam int unsigned SH = sedt_pkg::UB_SHIFT;
  localparam int unsigned EW = CW + SH;

  sedt_pkg::state_t state_r, state_nxt;

  logic [31:0]   filter_r;
  logic [CW-1:0] cap_r;
  logic          any_seen_r;
  logic [63:0]   early_r, late_r;
  sedt_pkg::in_word_t item_r;
  logic [AW-1:0] clr_r;

  // Walk registers: current, first and last word, and the bit bounds at the ends.
  logic [AW-1:0] w_r, w0_r, w1_r;
  logic [5:0]    b0_r, b1_r;
  logic          hit_r, found_r;
  logic [UW-1:0] first_u_r, last_u_r;

  logic          out_valid_r;
  sedt_pkg::out_word_t out_r;

  // RAM signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  sedt_map_ram u_map (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Effective capacity and range decode.
  logic [CW-1:0] eff_cap, cap_m1;
  logic [EW-1:0] cap_end;
  logic [31:0]   rec_size;
  logic [64:0]   rec_end;
  logic [EW-1:0] end_clip, end_m1;
  logic          rec_match, rec_mark;
  logic [UW-1:0] rec_u0, rec_u1;
  logic [64:0]   q_last;
  logic          q_ok;
  logic [UW-1:0] q_u0, q_u1;
  logic [5:0]    lo_bit, hi_bit;
  logic [63:0]   span, masked;
  logic          last_word;

  always_comb begin
    eff_cap  = (cap_r > CW'(sedt_pkg::UNITS)) ? CW'(sedt_pkg::UNITS) : cap_r;
    cap_m1   = eff_cap - CW'(1);
    cap_end  = {eff_cap, {SH{1'b0}}};
    rec_size = (item_r.rec_len != 32'd0) ? item_r.rec_len : 32'd1;
    rec_end  = {1'b0, item_r.dev_off} + {33'd0, rec_size};
    rec_match = !item_r.record_blank && (item_r.sess_no == {32'd0, filter_r});
    rec_mark = (eff_cap != '0) && !rec_end[64]
               && (item_r.dev_off < {{(64-EW){1'b0}}, cap_end});
    end_clip = (rec_end[63:0] > {{(64-EW){1'b0}}, cap_end}) ? cap_end : rec_end[EW-1:0];
    end_m1   = end_clip - EW'(1);
    rec_u0   = item_r.dev_off[SH +: UW];
    rec_u1   = end_m1[SH +: UW];
    // Overlap range; count is at least one when q_ok is used.
    q_last   = {1'b0, item_r.start_unit} + {1'b0, item_r.unit_count} - 65'd1;
    q_ok     = (item_r.unit_count != 64'd0) && !q_last[64]
               && (item_r.start_unit < {{(64-CW){1'b0}}, eff_cap});
    q_u0     = item_r.start_unit[UW-1:0];
    q_u1     = (q_last[63:0] >= {{(64-CW){1'b0}}, eff_cap}) ? cap_m1[UW-1:0]
                                                           : q_last[UW-1:0];
    lo_bit    = (w_r == w0_r) ? b0_r : 6'd0;
    hi_bit    = (w_r == w1_r) ? b1_r : 6'd63;
    span      = sedt_pkg::bit_span(lo_bit, hi_bit);
    masked    = ram_rdata & span;
    last_word = (w_r == w1_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sedt_pkg::ST_CLEAR: begin
        if (clr_r == AW'(sedt_pkg::MAP_WORDS - 1)) state_nxt = sedt_pkg::ST_IDLE;
      end
      sedt_pkg::ST_IDLE:   if (in_valid) state_nxt = sedt_pkg::ST_DECODE;
      sedt_pkg::ST_DECODE: begin
        unique case (sedt_pkg::kind_t'(item_r.kind))
          sedt_pkg::KIND_RECORD:
            state_nxt = (rec_match && rec_mark) ? sedt_pkg::ST_READ : sedt_pkg::ST_FINISH;
          sedt_pkg::KIND_OVERLAP:
            state_nxt = q_ok ? sedt_pkg::ST_READ : sedt_pkg::ST_FINISH;
          sedt_pkg::KIND_SUMMARY:
            state_nxt = (eff_cap != '0) ? sedt_pkg::ST_READ : sedt_pkg::ST_FINISH;
          default: state_nxt = sedt_pkg::ST_FINISH;
        endcase
      end
      sedt_pkg::ST_READ:   state_nxt = sedt_pkg::ST_CHECK;
      sedt_pkg::ST_CHECK:  state_nxt = last_word ? sedt_pkg::ST_FINISH : sedt_pkg::ST_READ;
      sedt_pkg::ST_FINISH: if (!out_valid_r || out_ready) state_nxt = sedt_pkg::ST_IDLE;
      default:             state_nxt = sedt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory controls and input handshake.
  always_comb begin
    in_ready  = (state_r == sedt_pkg::ST_IDLE);
    ram_raddr = w_r;
    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = ram_rdata | span;
    unique case (state_r)
      sedt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      sedt_pkg::ST_CHECK: begin
        ram_we = (item_r.kind == sedt_pkg::KIND_RECORD);
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sedt_pkg::ST_CLEAR;
      clr_r       <= '0;
      filter_r    <= '0;
      cap_r       <= CW'(sedt_pkg::UNITS);
      any_seen_r  <= 1'b0;
      early_r     <= '0;
      late_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (sedt_pkg::reg_index_t'(cfg_index))
          sedt_pkg::REG_SESSION_FILTER: filter_r <= cfg_data;
          sedt_pkg::REG_CAPACITY_UNITS: cap_r    <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      if (state_r == sedt_pkg::ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (state_r == sedt_pkg::ST_DECODE && item_r.kind == sedt_pkg::KIND_RECORD
          && rec_match) begin
        any_seen_r <= 1'b1;
        if (!any_seen_r || item_r.timestamp < early_r) early_r <= item_r.timestamp;
        if (!any_seen_r || item_r.timestamp > late_r)  late_r  <= item_r.timestamp;
      end
      // A finished item loads the output register whenever it is free or
      // being drained in the same cycle.
      if (state_r == sedt_pkg::ST_FINISH && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    unique case (state_r)
      sedt_pkg::ST_DECODE: begin
        hit_r   <= 1'b0;
        found_r <= 1'b0;
        if (item_r.kind == sedt_pkg::KIND_RECORD) begin
          w0_r <= rec_u0[UW-1:6];
          w1_r <= rec_u1[UW-1:6];
          w_r  <= rec_u0[UW-1:6];
          b0_r <= rec_u0[5:0];
          b1_r <= rec_u1[5:0];
        end else if (item_r.kind == sedt_pkg::KIND_OVERLAP) begin
          w0_r <= q_u0[UW-1:6];
          w1_r <= q_u1[UW-1:6];
          w_r  <= q_u0[UW-1:6];
          b0_r <= q_u0[5:0];
          b1_r <= q_u1[5:0];
        end else begin
          w0_r <= '0;
          w1_r <= cap_m1[UW-1:6];
          w_r  <= '0;
          b0_r <= '0;
          b1_r <= cap_m1[5:0];
        end
      end
      sedt_pkg::ST_CHECK: begin
        if (!last_word) w_r <= w_r + AW'(1);
        if (masked != 64'd0) begin
          hit_r   <= 1'b1;
          found_r <= 1'b1;
          if (!found_r) first_u_r <= {w_r, sedt_pkg::lowest_bit(masked)};
          last_u_r <= {w_r, sedt_pkg::highest_bit(masked)};
        end
      end
      sedt_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_r.status     <= (item_r.kind == sedt_pkg::KIND_SUMMARY) && !found_r;
          out_r.overlaps   <= (item_r.kind == sedt_pkg::KIND_OVERLAP) && hit_r;
          out_r.any_record <= any_seen_r;
          out_r.first_time <= early_r;
          out_r.last_time  <= late_r;
          if (item_r.kind == sedt_pkg::KIND_SUMMARY && found_r) begin
            out_r.first_byte <= {{(64-UW-SH){1'b0}}, first_u_r, {SH{1'b0}}};
            out_r.last_byte  <= {{(64-UW-SH){1'b0}}, last_u_r, {SH{1'b1}}};
          end else begin
            out_r.first_byte <= '0;
            out_r.last_byte  <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- verif/extent_checker.sv -----
`timescale 1ns / 1ps
module extent_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sedt_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sedt_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  logic [63:0] map_mem [sedt_pkg::MAP_WORDS];
  logic        seen;
  logic [63:0] t_min, t_max;
  logic [31:0] filter_q;
  logic [16:0] cap_q;
  sedt_pkg::out_word_t due_q[$];

  function automatic logic [63:0] cap_eff();
    return (cap_q > sedt_pkg::UNITS) ? 64'(sedt_pkg::UNITS) : 64'(cap_q);
  endfunction

  function automatic bit unit_set(logic [63:0] u);
    return map_mem[u[63:6]][u[5:0]];
  endfunction

  function automatic void track_record(sedt_pkg::in_word_t w);
    logic [63:0] cap, cap_end, lim, u;
    cap = cap_eff();
    if (!seen) begin
      t_min = w.timestamp;
      t_max = w.timestamp;
      seen  = 1'b1;
    end else begin
      if (w.timestamp < t_min) t_min = w.timestamp;
      if (w.timestamp > t_max) t_max = w.timestamp;
    end
    if (cap == 0) return;
    cap_end = cap * sedt_pkg::BLOCK_SIZE;
    lim = w.dev_off + ((w.rec_len != 0) ? 64'(w.rec_len) : 64'd1);
    if (lim <= w.dev_off || w.dev_off >= cap_end) return;
    if (lim > cap_end) lim = cap_end;
    for (u = w.dev_off / sedt_pkg::BLOCK_SIZE;
         u <= (lim - 1) / sedt_pkg::BLOCK_SIZE && u < cap; u++)
      map_mem[u[63:6]][u[5:0]] = 1'b1;
  endfunction

  function automatic bit range_hit(logic [63:0] s, logic [63:0] n);
    logic [63:0] cap, e, u;
    cap = cap_eff();
    if (n == 0) return 1'b0;
    e = s + n - 1;
    if (e < s || s >= cap) return 1'b0;
    if (e >= cap) e = cap - 1;
    for (u = s; u <= e; u++)
      if (unit_set(u)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic sedt_pkg::out_word_t predict(sedt_pkg::in_word_t w);
    sedt_pkg::out_word_t r;
    logic [63:0] cap, u;
    bit found;
    r = '0;
    case (sedt_pkg::kind_t'(w.kind))
      sedt_pkg::KIND_RECORD:
        if (!w.record_blank && w.sess_no == 64'(filter_q)) track_record(w);
      sedt_pkg::KIND_OVERLAP: r.overlaps = range_hit(w.start_unit, w.unit_count);
      sedt_pkg::KIND_SUMMARY: begin
        cap = cap_eff();
        found = 1'b0;
        for (u = 0; u < cap; u++) begin
          if (unit_set(u)) begin
            if (!found) r.first_byte = u * sedt_pkg::BLOCK_SIZE;
            r.last_byte = (u + 1) * sedt_pkg::BLOCK_SIZE - 1;
            found = 1'b1;
          end
        end
        r.status = !found;
      end
      default: ;
    endcase
    r.any_record = seen;
    r.first_time = t_min;
    r.last_time  = t_max;
    return r;
  endfunction

  always @(posedge clk) begin
    sedt_pkg::out_word_t e;
    if (!rst_n) begin
      foreach (map_mem[i]) map_mem[i] = '0;
      seen = 0; t_min = 0; t_max = 0;
      filter_q = 0; cap_q = 17'd65536;
      due_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = due_q.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) due_q.push_back(predict(in_data));
      if (cfg_valid && cfg_ready) begin
        if (sedt_pkg::reg_index_t'(cfg_index) == sedt_pkg::REG_SESSION_FILTER)
          filter_q = cfg_data;
        else cap_q = cfg_data[16:0];
      end
      pending <= due_q.size();
    end
  end
endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0, cfg_index = 1'b0;
  logic in_ready, out_valid, cfg_ready;
  sedt_pkg::in_word_t  in_data = '0;
  sedt_pkg::out_word_t out_data;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle = 29, recv_idle = 48;
  bit hold_rx = 1'b0;
  logic [31:0] sess = 0;
  logic [63:0] cap_now = 65536;
  int quiet = 0;

  always #5 clk = ~clk;

  session_extent_tracker_unit u_top (.*);

  extent_checker u_chk (.*);

  // The receiver stalls at random, or fully while a long hold-off is requested.
  always @(posedge clk)
    out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle);

  // Watchdog on progress: ends the run as a failure when handshakes stop.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 40000) begin
      $display("session_extent_tracker_unit regression: fail");
      $finish;
    end
  end

  // Valid stays up between back-to-back words; idle cycles and drain lower it.
  task automatic send_word(sedt_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every expected word is back, then for the block to settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(sedt_pkg::reg_index_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == sedt_pkg::REG_SESSION_FILTER) sess = v;
    else cap_now = (v[16:0] > sedt_pkg::UNITS) ? 64'(sedt_pkg::UNITS) : 64'(v[16:0]);
  endtask

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  function automatic sedt_pkg::in_word_t make_word(sedt_pkg::kind_t k);
    sedt_pkg::in_word_t w;
    logic [63:0] span;
    w = '0;
    w.kind = k;
    span = (cap_now + 2) * sedt_pkg::BLOCK_SIZE;
    w.record_blank = ($urandom_range(9) == 0);
    w.sess_no = ($urandom_range(7) == 0) ? r64() : 64'(sess);
    w.timestamp  = ($urandom_range(9) == 0) ? r64() : 64'($urandom_range(100000));
    w.dev_off = ($urandom_range(15) == 0) ? r64() : r64() % span;
    case ($urandom_range(3))
      0: w.rec_len = $urandom;
      1: w.rec_len = 0;
      default: w.rec_len = $urandom_range(3 * sedt_pkg::BLOCK_SIZE);
    endcase
    w.start_unit = ($urandom_range(9) == 0) ? r64() : r64() % (cap_now + 4);
    w.unit_count = ($urandom_range(9) == 0) ? r64() : 64'($urandom_range(130));
    return w;
  endfunction

  task automatic random_words(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      send_word(make_word(p < 70 ? sedt_pkg::KIND_RECORD :
                          p < 88 ? sedt_pkg::KIND_OVERLAP :
                          p < 97 ? sedt_pkg::KIND_SUMMARY : sedt_pkg::KIND_NONE));
    end
  endtask

  initial begin
    sedt_pkg::in_word_t w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: queries on an empty map, extremes, wraps, unused kind.
    send_word(make_word(sedt_pkg::KIND_SUMMARY));
    w = '0; w.kind = sedt_pkg::KIND_RECORD; w.record_blank = 1'b1; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_RECORD; w.timestamp = '1; w.rec_len = 0; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_RECORD; w.timestamp = 0;
    w.dev_off = 64'(sedt_pkg::UNITS) * sedt_pkg::BLOCK_SIZE - 1; w.rec_len = '1;
    send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_RECORD; w.dev_off = '1; w.rec_len = 2; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_RECORD; w.dev_off = '1; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_RECORD; w.sess_no = '1; w.dev_off = 8192; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_OVERLAP; w.start_unit = 0; w.unit_count = 0; send_word(w);
    w.unit_count = '1; send_word(w);
    w.start_unit = '1; w.unit_count = 2; send_word(w);
    w.start_unit = 64'(sedt_pkg::UNITS - 1); w.unit_count = 5; send_word(w);
    w.start_unit = 0; w.unit_count = 3; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_SUMMARY; send_word(w);
    w = '0; w = ~w; w.kind = sedt_pkg::KIND_NONE; send_word(w);
    drain();

    // Lower capacity below marked units, then back up, then zero.
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd3);
    w = '0; w.kind = sedt_pkg::KIND_SUMMARY; send_word(w);
    w = '0; w.kind = sedt_pkg::KIND_OVERLAP; w.start_unit = 0; w.unit_count = '1; send_word(w);
    drain();
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'h1FFFF);
    w = '0; w.kind = sedt_pkg::KIND_SUMMARY; send_word(w);
    drain();
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd0);
    w = '0; w.kind = sedt_pkg::KIND_RECORD; send_word(w);
    w.kind = sedt_pkg::KIND_SUMMARY; send_word(w);
    w.kind = sedt_pkg::KIND_OVERLAP; w.unit_count = 4; send_word(w);
    drain();

    // Phase one: sender idles less than receiver, small map.
    send_idle = 29; recv_idle = 48;
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd1);
    write_reg(sedt_pkg::REG_SESSION_FILTER, 32'hFFFF_FFFF);
    random_words(100);
    drain();
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd200);
    write_reg(sedt_pkg::REG_SESSION_FILTER, $urandom);
    random_words(200);

    // Long receiver hold-off while words keep coming.
    fork
      random_words(30);
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
    join
    drain();

    // Phase two: roles swapped.
    send_idle = 48; recv_idle = 29;
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd700);
    write_reg(sedt_pkg::REG_SESSION_FILTER, 32'd0);
    random_words(250);
    drain();

    // Phase three: no idling; full capacity for a few words only.
    send_idle = 0; recv_idle = 0;
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd65536);
    random_words(20);
    drain();
    write_reg(sedt_pkg::REG_CAPACITY_UNITS, 32'd96);
    random_words(200);
    drain();

    if (fail_count == 0) $display("session_extent_tracker_unit regression: pass");
    else $display("session_extent_tracker_unit regression: fail");
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/sedt_pkg.sv
hw/rtl/sedt_map_ram.sv
hw/rtl/session_extent_tracker_unit.sv
verif/extent_checker.sv
verif/testbench.sv
